[design/bfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg: shared types for the best-fit block string allocator
// Sequencer states and the control group broadcast to the cell chain.
// ----------------------------------------------------------------------------
package bfa_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_SEL,
        ST_MOVE
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic find;      // latch the selected cell
        logic move_en;   // write the updated record back into the chain
        logic shift_any; // the chosen record moves forward in the order
        logic exch;      // the move is an exchange rather than a shift
    } t_cell_ctl;

    localparam logic [15:0] STD_SIZE_RESET = 16'd8192;

endpackage

[design/best_fit_block_string_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_string_allocator: best-fit placement of strings in blocks
// A chain of cells keeps the blocks ordered by free space; each request is
// placed in the first block with room, or in a newly appended block.
// ----------------------------------------------------------------------------
//  Channel   Ports                                        Handshake
//  request   start, i_string_length                       start && !busy
//  result    o_strobe, o_block_id, o_offset, o_new_block,  o_strobe, one cycle
//            o_table_full
//  config    i_cfg_we, i_cfg_wdata                        i_cfg_we
//
// A request passes through a search across all cells, selection of the
// chosen record and reinsertion in the chain; the table-full case skips
// reinsertion. The result beat is registered in the selection state; busy
// stays high until reinsertion is done. The receiver cannot stall the result.
// Reset empties the block table and sets the standard size to 8192.
// ----------------------------------------------------------------------------
module best_fit_block_string_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_string_length,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [3:0]  o_block_id,
    output logic [15:0] o_offset,
    output logic        o_new_block,
    output logic        o_table_full
);

    localparam int SW = SIZE_WIDTH;
    localparam int NW = ((SIZE_WIDTH > 16) ? SIZE_WIDTH : 16) + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [NW-1:0] SMAX = {{(NW-SW){1'b0}}, {SW{1'b1}}};
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

    bfa_pkg::t_state    r_state;
    bfa_pkg::t_state    n_state;
    bfa_pkg::t_cell_ctl ctl;

    logic [15:0]   r_std;
    logic [CW-1:0] r_count;
    logic [NW-1:0] r_need;
    logic          r_any_hit;
    logic [SW-1:0] r_rec_free;
    logic [SW-1:0] r_rec_size;
    logic [IW-1:0] r_rec_id;

    logic          r_strobe;
    logic [3:0]    r_block_id;
    logic [15:0]   r_offset;
    logic          r_new_block;
    logic          r_table_full;

    logic [MAX_BLOCKS-1:0] valid;
    logic [MAX_BLOCKS:0]   hit_seen;
    logic [MAX_BLOCKS:0]   sel_seen;
    logic [MAX_BLOCKS-1:0] sel;
    logic [MAX_BLOCKS-1:0] gt;
    logic [MAX_BLOCKS-1:0] is_p;
    logic [MAX_BLOCKS-1:0] neq;
    logic [SW-1:0]         c_free [MAX_BLOCKS];
    logic [SW-1:0]         c_size [MAX_BLOCKS];
    logic [IW-1:0]         c_id   [MAX_BLOCKS];

    logic [SW-1:0] sel_free;
    logic [SW-1:0] sel_size;
    logic [IW-1:0] sel_id;
    logic [SW-1:0] p_free;
    logic [SW-1:0] p_size;
    logic [IW-1:0] p_id;
    logic          full_now;
    logic [NW-1:0] std_clamp;
    logic [NW-1:0] new_size;
    logic [SW-1:0] ch_free;
    logic [SW-1:0] ch_size;
    logic [IW-1:0] ch_id;

    assign busy         = (r_state != bfa_pkg::ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_block_id   = r_block_id;
    assign o_offset     = r_offset;
    assign o_new_block  = r_new_block;
    assign o_table_full = r_table_full;

    assign hit_seen[0] = 1'b0;
    assign sel_seen[0] = 1'b0;

    always_comb begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            valid[i] = (CW'(i) < r_count);
        end
    end

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        bfa_cell #(
            .SW(SW),
            .NW(NW),
            .IW(IW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_valid     (valid[g]),
            .i_prev_valid((g == 0) ? 1'b1 : valid[(g == 0) ? 0 : g-1]),
            .i_need      (r_need),
            .i_any_hit   (hit_seen[MAX_BLOCKS]),
            .i_hit_seen  (hit_seen[g]),
            .o_hit_seen  (hit_seen[g+1]),
            .i_sel_seen  (sel_seen[g]),
            .o_sel_seen  (sel_seen[g+1]),
            .o_sel       (sel[g]),
            .i_rec_free  (r_rec_free),
            .i_rec_size  (r_rec_size),
            .i_rec_id    (r_rec_id),
            .i_prev_gt   ((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g-1]),
            .o_gt        (gt[g]),
            .o_is_p      (is_p[g]),
            .o_neq       (neq[g]),
            .i_prev_free (c_free[(g == 0) ? 0 : g-1]),
            .i_prev_size (c_size[(g == 0) ? 0 : g-1]),
            .i_prev_id   (c_id[(g == 0) ? 0 : g-1]),
            .i_p_free    (p_free),
            .i_p_size    (p_size),
            .i_p_id      (p_id),
            .o_free      (c_free[g]),
            .o_size      (c_size[g]),
            .o_id        (c_id[g])
        );
    end

    // One-hot selections of the chosen cell and of the insertion point.
    always_comb begin
        sel_free = '0;
        sel_size = '0;
        sel_id   = '0;
        p_free   = '0;
        p_size   = '0;
        p_id     = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            sel_free = sel_free | (c_free[i] & {SW{sel[i]}});
            sel_size = sel_size | (c_size[i] & {SW{sel[i]}});
            sel_id   = sel_id   | (c_id[i]   & {IW{sel[i]}});
            p_free   = p_free   | (c_free[i] & {SW{is_p[i]}});
            p_size   = p_size   | (c_size[i] & {SW{is_p[i]}});
            p_id     = p_id     | (c_id[i]   & {IW{is_p[i]}});
        end
    end

    always_comb begin
        full_now  = !r_any_hit && ((r_count == CNT_MAX) || (r_need > SMAX));
        std_clamp = (NW'(r_std) > SMAX) ? SMAX : NW'(r_std);
        new_size  = (std_clamp > r_need) ? std_clamp : r_need;
        if (r_any_hit) begin
            ch_free = sel_free;
            ch_size = sel_size;
            ch_id   = sel_id;
        end else begin
            ch_free = new_size[SW-1:0];
            ch_size = new_size[SW-1:0];
            ch_id   = IW'(r_count);
        end
    end

    always_comb begin
        unique case (r_state)
            bfa_pkg::ST_IDLE: n_state = start ? bfa_pkg::ST_FIND : bfa_pkg::ST_IDLE;
            bfa_pkg::ST_FIND: n_state = bfa_pkg::ST_SEL;
            bfa_pkg::ST_SEL:  n_state = full_now ? bfa_pkg::ST_IDLE : bfa_pkg::ST_MOVE;
            bfa_pkg::ST_MOVE: n_state = bfa_pkg::ST_IDLE;
            default:          n_state = bfa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.find      = (r_state == bfa_pkg::ST_FIND);
        ctl.move_en   = (r_state == bfa_pkg::ST_MOVE);
        ctl.shift_any = |gt;
        ctl.exch      = !(|neq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfa_pkg::ST_IDLE;
            r_std    <= bfa_pkg::STD_SIZE_RESET;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == bfa_pkg::ST_SEL);
            if (i_cfg_we) begin
                r_std <= i_cfg_wdata;
            end
            if ((r_state == bfa_pkg::ST_SEL) && !full_now && !r_any_hit) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == bfa_pkg::ST_IDLE) && start) begin
            r_need <= NW'(i_string_length) + 1'b1;
        end
        if (r_state == bfa_pkg::ST_FIND) begin
            r_any_hit <= hit_seen[MAX_BLOCKS];
        end
        if (r_state == bfa_pkg::ST_SEL) begin
            r_rec_free <= ch_free - r_need[SW-1:0];
            r_rec_size <= ch_size;
            r_rec_id   <= ch_id;
            if (full_now) begin
                r_block_id   <= '0;
                r_offset     <= '0;
                r_new_block  <= 1'b0;
                r_table_full <= 1'b1;
            end else begin
                r_block_id   <= 4'(ch_id);
                r_offset     <= 16'(ch_size - ch_free);
                r_new_block  <= !r_any_hit;
                r_table_full <= 1'b0;
            end
        end
    end

endmodule

[design/bfa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_cell: one entry of the sorted block chain
// Holds the free space, size and id of one block, takes part in the
// first-fit search and in the reinsertion that keeps the chain in order.
// ----------------------------------------------------------------------------
module bfa_cell #(
    parameter int SW = 16,
    parameter int NW = 17,
    parameter int IW = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfa_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,
    input  logic              i_prev_valid,
    input  logic [NW-1:0]     i_need,
    input  logic              i_any_hit,
    input  logic              i_hit_seen,
    output logic              o_hit_seen,
    input  logic              i_sel_seen,
    output logic              o_sel_seen,
    output logic              o_sel,
    input  logic [SW-1:0]     i_rec_free,
    input  logic [SW-1:0]     i_rec_size,
    input  logic [IW-1:0]     i_rec_id,
    input  logic              i_prev_gt,
    output logic              o_gt,
    output logic              o_is_p,
    output logic              o_neq,
    input  logic [SW-1:0]     i_prev_free,
    input  logic [SW-1:0]     i_prev_size,
    input  logic [IW-1:0]     i_prev_id,
    input  logic [SW-1:0]     i_p_free,
    input  logic [SW-1:0]     i_p_size,
    input  logic [IW-1:0]     i_p_id,
    output logic [SW-1:0]     o_free,
    output logic [SW-1:0]     o_size,
    output logic [IW-1:0]     o_id
);

    logic [SW-1:0] r_free;
    logic [SW-1:0] r_size;
    logic [IW-1:0] r_id;
    logic          r_sel;
    logic          hit;
    logic          first_hit;
    logic          tail;
    logic          ahead;
    logic          load_rec;
    logic          load_prev;
    logic          load_p;

    assign hit        = i_valid && ({{(NW-SW){1'b0}}, r_free} >= i_need);
    assign first_hit  = hit && !i_hit_seen;
    assign o_hit_seen = i_hit_seen || hit;
    // The first unused cell is where a new block is appended.
    assign tail       = !i_valid && i_prev_valid;

    assign o_sel_seen = i_sel_seen || r_sel;
    assign ahead      = !o_sel_seen;
    assign o_sel      = r_sel;

    assign o_gt   = ahead && (r_free > i_rec_free);
    assign o_is_p = o_gt && !i_prev_gt;
    assign o_neq  = o_gt && i_prev_gt && (r_free != i_prev_free);

    assign o_free = r_free;
    assign o_size = r_size;
    assign o_id   = r_id;

    always_comb begin
        load_rec  = i_ctl.shift_any ? o_is_p : r_sel;
        load_prev = i_ctl.shift_any && !i_ctl.exch && ((o_gt && !o_is_p) || r_sel);
        load_p    = i_ctl.shift_any && i_ctl.exch && r_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (i_ctl.find) begin
            r_sel <= first_hit || (!i_any_hit && tail);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.move_en) begin
            if (load_rec) begin
                r_free <= i_rec_free;
                r_size <= i_rec_size;
                r_id   <= i_rec_id;
            end else if (load_prev) begin
                r_free <= i_prev_free;
                r_size <= i_prev_size;
                r_id   <= i_prev_id;
            end else if (load_p) begin
                r_free <= i_p_free;
                r_size <= i_p_size;
                r_id   <= i_p_id;
            end
        end
    end

endmodule
